### hw/rtl/mexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Word width, register indexes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int WORD_BITS    = 32;
    localparam int CNT_BITS     = $clog2(WORD_BITS);
    localparam int CFG_IDX_BITS = 8;

    typedef logic [WORD_BITS-1:0]    t_word;
    typedef logic [CNT_BITS-1:0]     t_cnt;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cnt LAST_CNT = CNT_BITS'(WORD_BITS - 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MODULUS  = 8'd0,
        REG_EXPONENT = 8'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MSEL_REDUCE,
        MSEL_SQUARE,
        MSEL_MULT
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_GO,
        ST_RED_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_NEXT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     exp_shift;
        logic     res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_busy;
        logic exp_bit;
        logic exp_last;
        logic res_full;
    } t_dp_sts;

endpackage
`default_nettype wire

### hw/rtl/mexp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation channel interfaces
// Message input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface mexp_msg_if;
    logic              valid;
    logic              ready;
    mexp_pkg::t_word   message;

    modport source (output valid, output message, input ready);
    modport sink (input valid, input message, output ready);
endinterface

interface mexp_res_if;
    logic              valid;
    logic              ready;
    mexp_pkg::t_word   result;

    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

interface mexp_cfg_if;
    logic               valid;
    logic               ready;
    mexp_pkg::t_cfg_idx index;
    mexp_pkg::t_word    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/mexp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences reduction, square and multiply passes over the exponent bits.
// ----------------------------------------------------------------------------
module mexp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output mexp_pkg::t_dp_cmd      o_cmd,
    input  wire mexp_pkg::t_dp_sts i_sts
);

    mexp_pkg::t_state r_state;
    mexp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mexp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mexp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = mexp_pkg::ST_RED_GO;
                end
            end
            mexp_pkg::ST_RED_GO:   n_state = mexp_pkg::ST_RED_WAIT;
            mexp_pkg::ST_RED_WAIT: begin
                if (!i_sts.mul_busy) begin
                    n_state = mexp_pkg::ST_SQ_GO;
                end
            end
            mexp_pkg::ST_SQ_GO:    n_state = mexp_pkg::ST_SQ_WAIT;
            mexp_pkg::ST_SQ_WAIT: begin
                if (!i_sts.mul_busy) begin
                    n_state = i_sts.exp_bit ? mexp_pkg::ST_MUL_GO : mexp_pkg::ST_NEXT;
                end
            end
            mexp_pkg::ST_MUL_GO:   n_state = mexp_pkg::ST_MUL_WAIT;
            mexp_pkg::ST_MUL_WAIT: begin
                if (!i_sts.mul_busy) begin
                    n_state = mexp_pkg::ST_NEXT;
                end
            end
            mexp_pkg::ST_NEXT: begin
                n_state = i_sts.exp_last ? mexp_pkg::ST_FIN : mexp_pkg::ST_SQ_GO;
            end
            mexp_pkg::ST_FIN: begin
                if (!i_sts.res_full) begin
                    n_state = mexp_pkg::ST_IDLE;
                end
            end
            default: n_state = mexp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.mul_start = 1'b0;
        o_cmd.mul_sel   = mexp_pkg::MSEL_REDUCE;
        o_cmd.exp_shift = 1'b0;
        o_cmd.res_load  = 1'b0;
        case (r_state)
            mexp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            mexp_pkg::ST_RED_GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = mexp_pkg::MSEL_REDUCE;
            end
            mexp_pkg::ST_SQ_GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = mexp_pkg::MSEL_SQUARE;
            end
            mexp_pkg::ST_MUL_GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = mexp_pkg::MSEL_MULT;
            end
            mexp_pkg::ST_NEXT: begin
                o_cmd.exp_shift = 1'b1;
            end
            mexp_pkg::ST_FIN: begin
                o_cmd.res_load = !i_sts.res_full;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/mexp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Key registers, bit-serial modular multiplier, exponent shifter and the
// result output register.
// ----------------------------------------------------------------------------
module mexp_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire mexp_pkg::t_cfg_idx  i_cfg_idx,
    input  wire mexp_pkg::t_word     i_cfg_data,
    input  wire mexp_pkg::t_word     i_msg,
    input  wire mexp_pkg::t_dp_cmd   i_cmd,
    output mexp_pkg::t_dp_sts        o_sts,
    output mexp_pkg::t_word          o_res,
    output logic                     o_res_valid,
    input  wire logic                i_res_ready
);

    localparam int W = mexp_pkg::WORD_BITS;

    mexp_pkg::t_word    r_modulus;
    mexp_pkg::t_word    r_exponent;
    mexp_pkg::t_word    r_base;
    mexp_pkg::t_word    r_acc;
    mexp_pkg::t_word    r_exp_sh;
    mexp_pkg::t_cnt     r_ecnt;
    mexp_pkg::t_word    r_mop_a;
    mexp_pkg::t_word    r_mop_b;
    mexp_pkg::t_word    r_mac;
    mexp_pkg::t_cnt     r_mcnt;
    mexp_pkg::t_mul_sel r_msel;
    logic               r_mul_busy;
    mexp_pkg::t_word    r_res;
    logic               r_res_valid;

    logic               mod_zero;
    logic [W:0]         dbl;
    logic [W:0]         dsub;
    mexp_pkg::t_word    dred;
    mexp_pkg::t_word    addend;
    logic [W:0]         sum;
    logic [W:0]         ssub;
    mexp_pkg::t_word    n_mac;
    mexp_pkg::t_word    acc_init;
    logic               mul_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= W'(1);
            r_exponent <= W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mexp_pkg::REG_MODULUS:  r_modulus  <= i_cfg_data;
                mexp_pkg::REG_EXPONENT: r_exponent <= i_cfg_data;
                default:                r_modulus  <= r_modulus;
            endcase
        end
    end

    always_comb begin
        mod_zero = (r_modulus == '0);
        dbl      = {r_mac, 1'b0};
        dsub     = dbl - {1'b0, r_modulus};
        if (mod_zero || dsub[W]) begin
            dred = dbl[W-1:0];
        end else begin
            dred = dsub[W-1:0];
        end
        addend = r_mop_b[W-1] ? r_mop_a : '0;
        sum    = {1'b0, dred} + {1'b0, addend};
        ssub   = sum - {1'b0, r_modulus};
        if (mod_zero || ssub[W]) begin
            n_mac = sum[W-1:0];
        end else begin
            n_mac = ssub[W-1:0];
        end
        acc_init = (r_modulus == W'(1)) ? '0 : W'(1);
        mul_fin  = r_mul_busy && (r_mcnt == mexp_pkg::LAST_CNT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy <= 1'b0;
        end else if (i_cmd.mul_start) begin
            r_mul_busy <= 1'b1;
        end else if (mul_fin) begin
            r_mul_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mac  <= '0;
            r_mcnt <= '0;
            r_msel <= i_cmd.mul_sel;
            case (i_cmd.mul_sel)
                mexp_pkg::MSEL_REDUCE: begin
                    r_mop_a <= W'(1);
                    r_mop_b <= r_base;
                end
                mexp_pkg::MSEL_SQUARE: begin
                    r_mop_a <= r_acc;
                    r_mop_b <= r_acc;
                end
                default: begin
                    r_mop_a <= r_base;
                    r_mop_b <= r_acc;
                end
            endcase
        end else if (r_mul_busy) begin
            r_mac   <= n_mac;
            r_mcnt  <= r_mcnt + 1'b1;
            r_mop_b <= {r_mop_b[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base   <= i_msg;
            r_acc    <= mod_zero ? W'(1) : acc_init;
            r_exp_sh <= r_exponent;
            r_ecnt   <= '0;
        end else begin
            if (mul_fin) begin
                if (r_msel == mexp_pkg::MSEL_REDUCE) begin
                    r_base <= n_mac;
                end else begin
                    r_acc <= n_mac;
                end
            end
            if (i_cmd.exp_shift) begin
                r_exp_sh <= {r_exp_sh[W-2:0], 1'b0};
                r_ecnt   <= r_ecnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res <= r_acc;
        end
    end

    assign o_sts.mul_busy = r_mul_busy;
    assign o_sts.exp_bit  = r_exp_sh[W-1];
    assign o_sts.exp_last = (r_ecnt == mexp_pkg::LAST_CNT);
    assign o_sts.res_full = r_res_valid;
    assign o_res          = r_res;
    assign o_res_valid    = r_res_valid;

endmodule
`default_nettype wire

### hw/rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation
// Raises each message word to the configured exponent modulo the configured
// modulus by square-and-multiply with a bit-serial modular multiplier.
//
//   Channel   Dir   Beat payload          Ready
//   i_msg     in    message               high while idle and out of reset
//   o_res     out   result                from consumer
//   i_cfg     in    index, data           high out of reset
//
// Each message takes one reduction, 32 squarings and one multiply per set
// exponent bit, each a modular multiply on the single multiplier, which
// takes one bit of the multiplier operand per cycle, plus an exponent shift
// step per exponent bit. Reset is synchronous and sets modulus and exponent
// to 1. A new message is taken while the previous result waits in the
// output register.
// ----------------------------------------------------------------------------
module modular_exponentiation (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mexp_msg_if.sink    i_msg,
    mexp_res_if.source  o_res,
    mexp_cfg_if.sink    i_cfg
);

    mexp_pkg::t_dp_cmd cmd;
    mexp_pkg::t_dp_sts sts;
    logic              in_ready;

    assign i_msg.ready = in_ready && i_rst_n;
    assign i_cfg.ready = i_rst_n;

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_msg.valid),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    mexp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_msg       (i_msg.message),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res       (o_res.result),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready)
    );

endmodule
`default_nettype wire
